// File: hdl/imusfd_pkg.sv
// ----------------------------------------------------------------------------
// imusfd_pkg
// Types and constants shared by the sensor serial frame decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package imusfd_pkg;

  localparam int unsigned WIN_LEN   = 10;
  localparam int unsigned CNT_W     = 4;

  localparam logic [7:0] FRAME_HDR  = 8'h55;
  localparam logic [7:0] TYPE_ACCEL = 8'h51;
  localparam logic [7:0] TYPE_GYRO  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;

  localparam int unsigned AXIS_W    = 20;
  localparam int unsigned TEMP_W    = 15;

  // temperature offset in centidegrees
  localparam logic signed [TEMP_W-1:0] TEMP_OFS = 15'sd3653;
  // ceil(2^22 / 17) * 5: |t| * 100 / 340 == (|t| * TEMP_RCP) >> 22
  localparam logic [20:0] TEMP_RCP = 21'd1233620;
  localparam int unsigned TEMP_SHR  = 22;

  typedef enum logic [1:0] {
    KIND_ACCEL = 2'd0,
    KIND_GYRO  = 2'd1,
    KIND_ANGLE = 2'd2
  } kind_e;

  // raw fields of one accepted frame
  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
    logic signed [15:0] raw_t;
  } frame_t;

  // scaled result
  typedef struct packed {
    kind_e                     kind;
    logic signed [AXIS_W-1:0]  axis_x;
    logic signed [AXIS_W-1:0]  axis_y;
    logic signed [AXIS_W-1:0]  axis_z;
    logic signed [TEMP_W-1:0]  temp_centi;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/imusfd_frame_check.sv
// ----------------------------------------------------------------------------
// imusfd_frame_check
// Sliding byte window with running sum; detects valid frames and registers
// their raw fields.
// ----------------------------------------------------------------------------
`default_nettype none

module imusfd_frame_check (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic [7:0]            byte_i,
  output logic                       in_ready_o,
  input  wire logic                  adv_i,
  output logic                       frm_vld_o,
  output imusfd_pkg::frame_t         frm_o
);

  logic [7:0]                        win_q [imusfd_pkg::WIN_LEN];
  logic [7:0]                        sum_q, sum_d;
  logic [imusfd_pkg::CNT_W-1:0]      skip_q, skip_d;
  logic [imusfd_pkg::CNT_W-1:0]      fill_q, fill_d;
  logic                              frm_vld_q, frm_vld_d;
  imusfd_pkg::frame_t                frm_q, frm_d;

  logic in_fire;
  logic check;
  logic accept;
  logic known;
  imusfd_pkg::kind_e kind;

  assign in_ready_o = !frm_vld_q || adv_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign check  = (fill_q == imusfd_pkg::CNT_W'(imusfd_pkg::WIN_LEN)) &&
                  (skip_q == '0);
  assign accept = in_fire && check && (win_q[0] == imusfd_pkg::FRAME_HDR) &&
                  (sum_q == byte_i);

  always_comb begin
    known = 1'b1;
    kind  = imusfd_pkg::KIND_ACCEL;
    case (win_q[1])
      imusfd_pkg::TYPE_ACCEL: kind = imusfd_pkg::KIND_ACCEL;
      imusfd_pkg::TYPE_GYRO:  kind = imusfd_pkg::KIND_GYRO;
      imusfd_pkg::TYPE_ANGLE: kind = imusfd_pkg::KIND_ANGLE;
      default:                known = 1'b0;
    endcase
  end

  always_comb begin
    // window sum tracks entering and leaving bytes
    sum_d  = sum_q;
    skip_d = skip_q;
    fill_d = fill_q;
    if (in_fire) begin
      sum_d = sum_q + byte_i - win_q[0];
      if (accept) begin
        skip_d = imusfd_pkg::CNT_W'(imusfd_pkg::WIN_LEN);
      end else if (skip_q != '0) begin
        skip_d = skip_q - 1'b1;
      end
      if (fill_q != imusfd_pkg::CNT_W'(imusfd_pkg::WIN_LEN)) begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_comb begin
    frm_vld_d = frm_vld_q;
    if (in_ready_o) begin
      frm_vld_d = accept && known;
    end
    frm_d.kind  = kind;
    frm_d.raw_x = {win_q[3], win_q[2]};
    frm_d.raw_y = {win_q[5], win_q[4]};
    frm_d.raw_z = {win_q[7], win_q[6]};
    frm_d.raw_t = {win_q[9], win_q[8]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < imusfd_pkg::WIN_LEN; i++) begin
        win_q[i] <= '0;
      end
      sum_q     <= '0;
      skip_q    <= '0;
      fill_q    <= '0;
      frm_vld_q <= 1'b0;
    end else begin
      if (in_fire) begin
        for (int i = 0; i < imusfd_pkg::WIN_LEN - 1; i++) begin
          win_q[i] <= win_q[i+1];
        end
        win_q[imusfd_pkg::WIN_LEN-1] <= byte_i;
      end
      sum_q     <= sum_d;
      skip_q    <= skip_d;
      fill_q    <= fill_d;
      frm_vld_q <= frm_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      frm_q <= frm_d;
    end
  end

  assign frm_vld_o = frm_vld_q;
  assign frm_o     = frm_q;

endmodule

`default_nettype wire

// File: hdl/imusfd_scale.sv
// ----------------------------------------------------------------------------
// imusfd_scale
// Constant scaling of raw axes to Q8 and temperature to centidegrees.
// ----------------------------------------------------------------------------
`default_nettype none

module imusfd_scale (
  input  wire imusfd_pkg::frame_t frm_i,
  output imusfd_pkg::result_t     res_o
);

  function automatic logic signed [imusfd_pkg::AXIS_W-1:0] scale_axis(
    input imusfd_pkg::kind_e kind,
    input logic signed [15:0] raw
  );
    logic signed [23:0] ext;
    logic signed [23:0] prod;
    logic signed [23:0] res;
    ext  = {{8{raw[15]}}, raw};
    prod = '0;
    res  = '0;
    // raw * scale * 256 / 32768, floored
    case (kind)
      imusfd_pkg::KIND_ACCEL: res = ext >>> 3;
      imusfd_pkg::KIND_GYRO: begin
        prod = ext * 24'sd125;
        res  = prod >>> 3;
      end
      imusfd_pkg::KIND_ANGLE: begin
        prod = ext * 24'sd45;
        res  = prod >>> 5;
      end
      default: res = '0;
    endcase
    return res[imusfd_pkg::AXIS_W-1:0];
  endfunction

  logic                              t_neg;
  logic [15:0]                       t_mag;
  logic [36:0]                       t_prod;
  logic signed [imusfd_pkg::TEMP_W-1:0] t_quo;

  always_comb begin
    t_neg  = frm_i.raw_t[15];
    t_mag  = t_neg ? 16'(-frm_i.raw_t) : 16'(frm_i.raw_t);
    t_prod = 37'(t_mag) * 37'(imusfd_pkg::TEMP_RCP);
    // quotient is truncated toward zero
    t_quo  = {1'b0, t_prod[imusfd_pkg::TEMP_SHR+13:imusfd_pkg::TEMP_SHR]};
    if (t_neg) begin
      t_quo = -t_quo;
    end
    res_o.kind       = frm_i.kind;
    res_o.axis_x     = scale_axis(frm_i.kind, frm_i.raw_x);
    res_o.axis_y     = scale_axis(frm_i.kind, frm_i.raw_y);
    res_o.axis_z     = scale_axis(frm_i.kind, frm_i.raw_z);
    res_o.temp_centi = t_quo + imusfd_pkg::TEMP_OFS;
  end

endmodule

`default_nettype wire

// File: hdl/imu_serial_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// imu_serial_frame_decoder_unit
// Decodes 11-byte sensor frames (header, type, three axes, temperature, sum)
// from a byte stream into scaled acceleration, angular rate or angle results.
// ----------------------------------------------------------------------------
//  channel   dir   tdata                         tuser
//  s_axis    in    rx_byte[7:0]                  -
//  m_axis    out   x[19:0] y[39:20] z[59:40]     kind[1:0]
//                  temp_centi[74:60]
//
//  one byte transfer per cycle while s_axis_tready is high; a result leaves after the
//  byte transfer that closes its frame (frame register, then result register)
//  s_axis_tready drops only while both stages hold results that m_axis stalls
//  reset clears the window, its running sum, the skip and fill counters and
//  both valid flags; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module imu_serial_frame_decoder_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,   // axis_x, axis_y, axis_z, temp_centi, pad
  output logic [1:0]       m_axis_tuser    // kind
);

  logic                 frm_vld;
  imusfd_pkg::frame_t   frm;
  imusfd_pkg::result_t  res;
  imusfd_pkg::result_t  out_q;
  logic                 out_vld_q, out_vld_d;
  logic                 out_en;

  assign out_en = !out_vld_q || m_axis_tready;

  imusfd_frame_check u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .byte_i     (s_axis_tdata),
    .in_ready_o (s_axis_tready),
    .adv_i      (out_en),
    .frm_vld_o  (frm_vld),
    .frm_o      (frm)
  );

  imusfd_scale u_scale (
    .frm_i (frm),
    .res_o (res)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_en) begin
      out_vld_d = frm_vld;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && frm_vld) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {5'd0, out_q.temp_centi, out_q.axis_z,
                          out_q.axis_y, out_q.axis_x};

endmodule

`default_nettype wire

// File: hdl/imusfd_checker.sv
// ----------------------------------------------------------------------------
// imusfd_checker
// Port-level checks of the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module imusfd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [79:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  // a held result keeps valid
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a held result keeps its contents
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // a new result follows its closing byte transfer through the frame and result registers
  a_out_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a closing byte transfer");

  // input side stalls only while the result is stalled
  a_in_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with free output");

  // tdata padding stays zero and kind stays in range on every result
  a_pad_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[79:75] == 5'd0) &&
                      (m_axis_tuser <= 2'(imusfd_pkg::KIND_ANGLE)))
    else $error("bad padding or kind in result");

endmodule

bind imu_serial_frame_decoder_unit imusfd_checker u_imusfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: tb/tb_imu_serial_frame_decoder_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_imu_serial_frame_decoder_unit
// Streams sensor bytes into the frame decoder: a few hand-built frames first
// (full-scale axes, every frame type, unknown type, bad sum and header, frames
// back to back, a frame hidden in the skip after another), then mostly well
// formed frames with random content mixed with noise and broken frames. A
// scoreboard predicts each scaled result from the byte stream and checks the
// output transfers in order, under random idling on both sides and a long
// output stall.
// ----------------------------------------------------------------------------

module tb_imu_serial_frame_decoder_unit;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int ACCEL_FS    = 16;
  localparam int GYRO_FS     = 2000;
  localparam int ANGLE_FS    = 180;
  localparam int TEMP_NUM    = 100;
  localparam int TEMP_DEN    = 340;

  typedef logic [7:0] frame_bytes_t [11];

  class frame_scoreboard;
    logic [7:0]  win [imusfd_pkg::WIN_LEN] = '{default: 8'h00};
    int unsigned skip_left = 0;
    int unsigned filled = 0;
    imusfd_pkg::result_t exp_q [$];
    int          fails = 0;

    // raw * scale * 256 / 32768, floored
    function logic signed [imusfd_pkg::AXIS_W-1:0] to_q8(logic signed [15:0] raw, int fs);
      longint p;
      p = longint'(raw) * fs;
      return imusfd_pkg::AXIS_W'(p >>> 7);
    endfunction

    function logic signed [imusfd_pkg::TEMP_W-1:0] to_centi(logic signed [15:0] raw);
      int t;
      t = raw;
      return imusfd_pkg::TEMP_W'((t * TEMP_NUM) / TEMP_DEN + int'(imusfd_pkg::TEMP_OFS));
    endfunction

    function void note_byte(logic [7:0] b);
      logic [7:0] sum;
      imusfd_pkg::result_t r;
      int         fs;
      bit         hit;
      int         i;
      hit = 1'b0;
      sum = 8'h00;
      fs  = 0;
      r   = '0;
      if (filled >= imusfd_pkg::WIN_LEN && skip_left == 0 &&
          win[0] == imusfd_pkg::FRAME_HDR) begin
        for (i = 0; i < imusfd_pkg::WIN_LEN; i++) sum += win[i];
        hit = (sum == b);
      end
      if (hit) begin
        case (win[1])
          imusfd_pkg::TYPE_ACCEL: begin fs = ACCEL_FS; r.kind = imusfd_pkg::KIND_ACCEL; end
          imusfd_pkg::TYPE_GYRO:  begin fs = GYRO_FS;  r.kind = imusfd_pkg::KIND_GYRO;  end
          imusfd_pkg::TYPE_ANGLE: begin fs = ANGLE_FS; r.kind = imusfd_pkg::KIND_ANGLE; end
          default:    fs = 0;
        endcase
        // unknown type still starts the skip, but yields nothing
        if (fs != 0) begin
          r.axis_x     = to_q8({win[3], win[2]}, fs);
          r.axis_y     = to_q8({win[5], win[4]}, fs);
          r.axis_z     = to_q8({win[7], win[6]}, fs);
          r.temp_centi = to_centi({win[9], win[8]});
          exp_q.push_back(r);
        end
      end
      if (skip_left > 0) skip_left--;
      if (hit) skip_left = imusfd_pkg::WIN_LEN;
      if (filled < imusfd_pkg::WIN_LEN) filled++;
      for (i = 0; i < imusfd_pkg::WIN_LEN - 1; i++) win[i] = win[i+1];
      win[imusfd_pkg::WIN_LEN-1] = b;
    endfunction

    function void check_result(imusfd_pkg::result_t got);
      imusfd_pkg::result_t want;
      if (exp_q.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected result: kind %0d x %0d y %0d z %0d temp %0d",
                   got.kind, got.axis_x, got.axis_y, got.axis_z, got.temp_centi);
        return;
      end
      want = exp_q.pop_front();
      if (got.kind != want.kind || got.axis_x != want.axis_x ||
          got.axis_y != want.axis_y || got.axis_z != want.axis_z ||
          got.temp_centi != want.temp_centi) begin
        fails++;
        if (fails <= 10) begin
          $display("result mismatch: expected kind %0d x %0d y %0d z %0d temp %0d",
                   want.kind, want.axis_x, want.axis_y, want.axis_z, want.temp_centi);
          $display("                 actual   kind %0d x %0d y %0d z %0d temp %0d",
                   got.kind, got.axis_x, got.axis_y, got.axis_z, got.temp_centi);
        end
      end
    endfunction

    function int pending();
      return exp_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic [7:0]  s_tdata;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic        m_tready;
  logic [79:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  frame_scoreboard sb;
  int  src_idle_pct = 0;
  int  snk_idle_pct = 0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  cycle_cnt = 0;

  imu_serial_frame_decoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),        // rx_byte[7:0]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),   // axis_x, axis_y, axis_z, temp_centi, pad
    .m_axis_tuser  (m_axis_tuser)    // kind
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_imu_serial_frame_decoder_unit failed");
      $finish;
    end
  end

  // output side: random stalls plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    imusfd_pkg::result_t got;
    if (rst_ni && m_axis_tvalid && m_tready) begin
      got.kind       = imusfd_pkg::kind_e'(m_axis_tuser);
      got.axis_x     = m_axis_tdata[19:0];
      got.axis_y     = m_axis_tdata[39:20];
      got.axis_z     = m_axis_tdata[59:40];
      got.temp_centi = m_axis_tdata[74:60];
      sb.check_result(got);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b);
  endtask

  task automatic send_bytes(input frame_bytes_t f, input int first, input int last);
    for (int i = first; i <= last; i++) send_byte(f[i]);
  endtask

  // hold the input until every predicted result has left the block
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic logic [7:0] frame_sum(frame_bytes_t f);
    logic [7:0] s;
    s = 8'h00;
    for (int i = 0; i < imusfd_pkg::WIN_LEN; i++) s += f[i];
    return s;
  endfunction

  function automatic void build_frame(output frame_bytes_t f, input logic [7:0] ty,
                                      input logic [15:0] x, input logic [15:0] y,
                                      input logic [15:0] z, input logic [15:0] t);
    f[0] = imusfd_pkg::FRAME_HDR;  f[1] = ty;
    f[2] = x[7:0];     f[3] = x[15:8];
    f[4] = y[7:0];     f[5] = y[15:8];
    f[6] = z[7:0];     f[7] = z[15:8];
    f[8] = t[7:0];     f[9] = t[15:8];
    f[10] = frame_sum(f);
  endfunction

  function automatic logic [15:0] rand_raw();
    case ($urandom_range(7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [7:0] rand_known_type();
    case ($urandom_range(2))
      0:       return imusfd_pkg::TYPE_ACCEL;
      1:       return imusfd_pkg::TYPE_GYRO;
      default: return imusfd_pkg::TYPE_ANGLE;
    endcase
  endfunction

  task automatic run_random(input int n_bytes);
    frame_bytes_t f;
    logic [7:0]   ty;
    int           stop_at;
    int           r;
    stop_at = 0;
    while (stop_at < n_bytes) begin
      r = $urandom_range(99);
      if (r < 77) begin
        if (r < 70) ty = rand_known_type();
        else begin
          do ty = 8'($urandom_range(255));
          while (ty inside {imusfd_pkg::TYPE_ACCEL, imusfd_pkg::TYPE_GYRO,
                            imusfd_pkg::TYPE_ANGLE});
        end
        build_frame(f, ty, rand_raw(), rand_raw(), rand_raw(), rand_raw());
        send_bytes(f, 0, 10);
        stop_at += 11;
      end else if (r < 85) begin
        build_frame(f, rand_known_type(), rand_raw(), rand_raw(), rand_raw(), rand_raw());
        f[10] = f[10] ^ 8'($urandom_range(1, 255));
        send_bytes(f, 0, 10);
        stop_at += 11;
      end else if (r < 90) begin
        build_frame(f, rand_known_type(), rand_raw(), rand_raw(), rand_raw(), rand_raw());
        do f[0] = 8'($urandom_range(255)); while (f[0] == imusfd_pkg::FRAME_HDR);
        send_bytes(f, 0, 10);
        stop_at += 11;
      end else if (r < 95) begin
        // frame cut short, the next one starts in its place
        build_frame(f, rand_known_type(), rand_raw(), rand_raw(), rand_raw(), rand_raw());
        r = $urandom_range(1, 9);
        send_bytes(f, 0, r);
        stop_at += r + 1;
      end else begin
        r = $urandom_range(1, 5);
        repeat (r) begin
          send_byte(($urandom_range(3) == 0) ? imusfd_pkg::FRAME_HDR :
                                               8'($urandom_range(255)));
        end
        stop_at += r;
      end
    end
  endtask

  initial begin
    frame_bytes_t f;
    frame_bytes_t g;
    sb       = new();
    rst_ni   = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 36;
    snk_idle_pct = 66;

    // header byte seen during start-up, window not yet full
    send_byte(imusfd_pkg::FRAME_HDR);
    send_byte(8'h00);
    // full-scale axes, each type, frames back to back
    build_frame(f, imusfd_pkg::TYPE_ACCEL, 16'h7fff, 16'h8000, 16'h0000, 16'h7fff);
    send_bytes(f, 0, 10);
    build_frame(f, imusfd_pkg::TYPE_GYRO, 16'h8000, 16'h7fff, 16'hffff, 16'h8000);
    send_bytes(f, 0, 10);
    build_frame(f, imusfd_pkg::TYPE_ANGLE, 16'h0001, 16'hffff, 16'h0080, 16'hffff);
    send_bytes(f, 0, 10);
    // unknown types are accepted silently
    build_frame(f, imusfd_pkg::TYPE_ACCEL - 8'd1, 16'h1234, 16'h5678, 16'h9abc, 16'h0000);
    send_bytes(f, 0, 10);
    build_frame(f, imusfd_pkg::TYPE_ANGLE + 8'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_bytes(f, 0, 10);
    // bad checksum, then bad header
    build_frame(f, imusfd_pkg::TYPE_GYRO, 16'hff80, 16'h0100, 16'h7fff, 16'hfeac);
    f[10] = f[10] + 8'd1;
    send_bytes(f, 0, 10);
    build_frame(f, imusfd_pkg::TYPE_ACCEL, 16'h0100, 16'h0200, 16'h0300, 16'h0154);
    f[0] = imusfd_pkg::FRAME_HDR ^ 8'h01;
    send_bytes(f, 0, 10);
    // a frame whose sum is the header: the frame it opens ends inside the skip
    build_frame(f, imusfd_pkg::TYPE_ACCEL, 16'h4000, 16'hc000, 16'h2000, 16'h0000);
    f[9]  = 8'h00;
    f[9]  = imusfd_pkg::FRAME_HDR - frame_sum(f);
    f[10] = imusfd_pkg::FRAME_HDR;
    send_bytes(f, 0, 10);
    build_frame(g, imusfd_pkg::TYPE_GYRO, 16'h0011, 16'h0022, 16'h0033, 16'h0044);
    send_bytes(g, 1, 10);
    build_frame(g, imusfd_pkg::TYPE_ANGLE, 16'h7fff, 16'h8000, 16'h0001, 16'h0022);
    send_bytes(g, 0, 10);
    drain_results();

    run_random(250);
    hold_req = 1'b1;
    run_random(280);
    drain_results();

    src_idle_pct = 66;
    snk_idle_pct = 36;
    run_random(530);
    drain_results();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_random(530);

    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (8) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("tb_imu_serial_frame_decoder_unit passed");
    end else begin
      $display("tb_imu_serial_frame_decoder_unit failed");
    end
    $finish;
  end

endmodule
